// ----- hw/rtl/sftri_pkg.sv -----
`default_nettype none

package sftri_pkg;

   localparam int WORD_W    = 16;
   localparam int MANT_W    = 12;
   localparam int EXP_W     = 4;
   localparam int OPERAND_W = 12;
   localparam int COEF_W    = 16;
   localparam int PRODUCT_W = OPERAND_W + COEF_W;
   localparam int RESULT_W  = 10;

   localparam logic [WORD_W-1:0] SF_NAN      = 16'h07FF;
   localparam logic [WORD_W-1:0] SF_NRES     = 16'h0800;
   localparam logic [WORD_W-1:0] SF_POS_INF  = 16'h07FE;
   localparam logic [WORD_W-1:0] SF_NEG_INF  = 16'h0802;
   localparam logic [WORD_W-1:0] SF_RESERVED = 16'h0801;

   localparam logic [MANT_W-1:0] LIMIT_E0 = 12'd300;
   localparam logic [MANT_W-1:0] LIMIT_E1 = 12'd30;
   localparam logic [MANT_W-1:0] LIMIT_E2 = 12'd3;

   localparam logic [OPERAND_W-1:0] HALF_D10   = 12'd5;
   localparam logic [OPERAND_W-1:0] HALF_D100  = 12'd50;
   localparam logic [OPERAND_W-1:0] HALF_D1000 = 12'd500;

   localparam logic [COEF_W-1:0] COEF_ONE     = 16'd1;
   localparam logic [COEF_W-1:0] COEF_TEN     = 16'd10;
   localparam logic [COEF_W-1:0] COEF_HUNDRED = 16'd100;
   localparam logic [COEF_W-1:0] RECIP_D10    = 16'd52429;
   localparam logic [COEF_W-1:0] RECIP_D100   = 16'd5243;
   localparam logic [COEF_W-1:0] RECIP_D1000  = 16'd8389;

   localparam int SHIFT_D10   = 19;
   localparam int SHIFT_D100  = 19;
   localparam int SHIFT_D1000 = 23;

   localparam logic [RESULT_W-1:0] INVALID_VALUE = '1;

   typedef enum logic [2:0] {
      MODE_BAD,
      MODE_PASS,
      MODE_MUL10,
      MODE_MUL100,
      MODE_DIV10,
      MODE_DIV100,
      MODE_DIV1000
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [OPERAND_W-1:0]   operand;
   } decode_type;

   typedef struct packed {
      mode_type               mode;
      logic [PRODUCT_W-1:0]   product;
   } scale_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sfloat_to_rounded_integer_top.sv -----
// Pipeline: an accepted request passes the decode, scale and finish registers in order.
// Throughput: one transfer per cycle; each stage holds while the one after it is full
// and stalled, and an empty stage takes a new item.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none

module sfloat_to_rounded_integer_top
   import sftri_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [WORD_W-1:0]     req_raw_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_int_value,
   output logic                       rsp_is_valid
);

   logic       s1_valid;
   logic       s2_valid;
   logic       s3_valid;
   decode_type s1_data;
   scale_type  s2_data;
   logic [RESULT_W-1:0] s3_value;
   logic       adv1;
   logic       adv2;
   logic       adv3;

   assign adv3 = !s3_valid || !rsp_stall;
   assign adv2 = !s2_valid || adv3;
   assign adv1 = !s1_valid || adv2;
   assign req_stall = !adv1;

   sftri_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv1),
      .valid_up (req_valid),
      .raw_word (req_raw_word),
      .valid_ff (s1_valid),
      .data_ff  (s1_data)
   );

   sftri_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv2),
      .valid_up (s1_valid),
      .data_up  (s1_data),
      .valid_ff (s2_valid),
      .data_ff  (s2_data)
   );

   sftri_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv3),
      .valid_up (s2_valid),
      .data_up  (s2_data),
      .valid_ff (s3_valid),
      .value_ff (s3_value),
      .ok_ff    (rsp_is_valid)
   );

   assign rsp_valid     = s3_valid;
   assign rsp_int_value = signed'(s3_value);

endmodule

`default_nettype wire

// ----- hw/rtl/sftri_decode.sv -----
`default_nettype none

module sftri_decode
   import sftri_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              valid_up,
   input  wire logic [WORD_W-1:0] raw_word,
   output logic                   valid_ff,
   output decode_type             data_ff
);

   logic       valid_in;
   decode_type data_in;
   logic [MANT_W-1:0] mant;
   logic [EXP_W-1:0]  expo;
   logic              special;

   assign mant = raw_word[MANT_W-1:0];
   assign expo = raw_word[WORD_W-1:MANT_W];
   assign special = (raw_word == SF_NAN) || (raw_word == SF_NRES) ||
                    (raw_word == SF_POS_INF) || (raw_word == SF_NEG_INF) ||
                    (raw_word == SF_RESERVED);
   assign valid_in = valid_up;

   always_comb begin
      data_in.mode    = MODE_BAD;
      data_in.operand = '0;
      if (!special && !mant[MANT_W-1]) begin
         case (expo)
            4'd0: begin
               if (mant <= LIMIT_E0) begin
                  data_in.mode    = MODE_PASS;
                  data_in.operand = mant;
               end
            end
            4'd1: begin
               if (mant <= LIMIT_E1) begin
                  data_in.mode    = MODE_MUL10;
                  data_in.operand = mant;
               end
            end
            4'd2: begin
               if (mant <= LIMIT_E2) begin
                  data_in.mode    = MODE_MUL100;
                  data_in.operand = mant;
               end
            end
            4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
               if (mant == '0) begin
                  data_in.mode = MODE_PASS;
               end
            end
            4'd13: begin
               data_in.mode    = MODE_DIV1000;
               data_in.operand = mant + HALF_D1000;
            end
            4'd14: begin
               data_in.mode    = MODE_DIV100;
               data_in.operand = mant + HALF_D100;
            end
            4'd15: begin
               data_in.mode    = MODE_DIV10;
               data_in.operand = mant + HALF_D10;
            end
            default: begin
               data_in.mode = MODE_PASS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sftri_scale.sv -----
`default_nettype none

module sftri_scale
   import sftri_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       valid_up,
   input  wire decode_type data_up,
   output logic            valid_ff,
   output scale_type       data_ff
);

   logic              valid_in;
   scale_type         data_in;
   logic [COEF_W-1:0] coef;

   assign valid_in = valid_up;

   always_comb begin
      case (data_up.mode)
         MODE_MUL10:   coef = COEF_TEN;
         MODE_MUL100:  coef = COEF_HUNDRED;
         MODE_DIV10:   coef = RECIP_D10;
         MODE_DIV100:  coef = RECIP_D100;
         MODE_DIV1000: coef = RECIP_D1000;
         default:      coef = COEF_ONE;
      endcase
   end

   always_comb begin
      data_in.mode    = data_up.mode;
      data_in.product = PRODUCT_W'(data_up.operand) * PRODUCT_W'(coef);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sftri_finish.sv -----
`default_nettype none

module sftri_finish
   import sftri_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              valid_up,
   input  wire scale_type         data_up,
   output logic                   valid_ff,
   output logic [RESULT_W-1:0]    value_ff,
   output logic                   ok_ff
);

   logic                 valid_in;
   logic [RESULT_W-1:0]  value_in;
   logic                 ok_in;
   logic [PRODUCT_W-1:0] shifted;

   assign valid_in = valid_up;

   always_comb begin
      case (data_up.mode)
         MODE_DIV10:   shifted = data_up.product >> SHIFT_D10;
         MODE_DIV100:  shifted = data_up.product >> SHIFT_D100;
         MODE_DIV1000: shifted = data_up.product >> SHIFT_D1000;
         default:      shifted = data_up.product;
      endcase
      ok_in    = (data_up.mode != MODE_BAD);
      value_in = ok_in ? shifted[RESULT_W-1:0] : INVALID_VALUE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
         ok_ff    <= ok_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import sftri_pkg::*;

   typedef struct {
      logic [WORD_W-1:0]          raw_word;
      logic signed [RESULT_W-1:0] int_value;
      logic                       is_valid;
   } sfloat_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [WORD_W-1:0]          req_raw_word = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [RESULT_W-1:0] rsp_int_value;
   logic                       rsp_is_valid;

   sfloat_result_type expected_results[$];

   int  error_count = 0;
   int  words_sent = 0;
   int  specials_sent = 0;
   int  in_range_seen = 0;
   int  rejected_seen = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   int  free_left = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;

   localparam logic [WORD_W-1:0] SPECIAL_CODES[5] = '{
      SF_NAN, SF_NRES, SF_POS_INF, SF_NEG_INF, SF_RESERVED
   };

   sfloat_to_rounded_integer_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_raw_word  (req_raw_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_int_value (rsp_int_value),
      .rsp_is_valid  (rsp_is_valid)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bit is_special_code(input logic [WORD_W-1:0] word);
      foreach (SPECIAL_CODES[i])
         if (word == SPECIAL_CODES[i])
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic sfloat_result_type decode_word(input logic [WORD_W-1:0] word);
      sfloat_result_type r;
      int mant;
      int expo;
      longint unsigned scale;
      longint unsigned value;
      r.raw_word  = word;
      r.int_value = INVALID_VALUE;
      r.is_valid  = 1'b0;
      mant = int'($signed(word[MANT_W-1:0]));
      expo = int'($signed(word[WORD_W-1:MANT_W]));
      if (is_special_code(word) || mant < 0)
         return r;
      scale = 1;
      for (int i = 0; i < ((expo < 0) ? -expo : expo); i++)
         scale = scale * 10;
      if (expo >= 0) begin
         value = longint'(mant) * scale;
         if (value > 300)
            return r;
      end else begin
         if (longint'(mant) > 300 * scale)
            return r;
         value = (2 * longint'(mant) + scale) / (2 * scale);
      end
      r.int_value = RESULT_W'(value);
      r.is_valid  = 1'b1;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 96)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (!receiver_idles) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (free_left > 0) begin
         rsp_stall <= 1'b0;
         free_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
         free_left  = $urandom_range(1, 12);
      end
   end

   always @(posedge clock) begin : check_responses
      sfloat_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response %0d/%0b with no transfer outstanding",
                                      rsp_int_value, rsp_is_valid));
         end else begin
            want = expected_results.pop_front();
            if (rsp_int_value !== want.int_value)
               report_mismatch($sformatf("word %h int_value %0d, want %0d",
                                         want.raw_word, rsp_int_value, want.int_value));
            if (rsp_is_valid !== want.is_valid)
               report_mismatch($sformatf("word %h is_valid %b, want %b",
                                         want.raw_word, rsp_is_valid, want.is_valid));
            if (want.is_valid)
               in_range_seen++;
            else
               rejected_seen++;
         end
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] word);
      int gap;
      req_valid    <= 1'b1;
      req_raw_word <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_results.push_back(decode_word(word));
      words_sent++;
      if (is_special_code(word))
         specials_sent++;
      @(negedge clock);
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_idling(input bit on_sender, input bit on_receiver);
      req_valid <= 1'b0;
      @(posedge clock);
      sender_idles   = on_sender;
      receiver_idles = on_receiver;
      @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      int roll;
      int e;
      int m;
      int d;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         return WORD_W'($urandom_range(0, 65535));
      if (roll < 30)
         return SPECIAL_CODES[$urandom_range(0, 4)];
      if (roll < 40)
         return {EXP_W'($urandom), 1'b1, 11'($urandom)};
      if (roll < 70) begin
         e = $urandom_range(0, 5) - 3;
         if (e >= 0) begin
            m = ((e == 0) ? 300 : (e == 1) ? 30 : 3) + $urandom_range(0, 4) - 2;
         end else begin
            d = (e == -1) ? 10 : (e == -2) ? 100 : 1000;
            m = $urandom_range(0, 2047 / d) * d + d / 2 + $urandom_range(0, 2) - 1;
            if (m > 2047)
               m = 2047;
            if (m < 0)
               m = 0;
         end
         return {EXP_W'(e), MANT_W'(m)};
      end
      if (roll < 85)
         return {EXP_W'($urandom), MANT_W'($urandom_range(0, 400))};
      return {EXP_W'($urandom), 1'b0, 11'($urandom)};
   endfunction

   task automatic test_directed_words();
      logic [WORD_W-1:0] words[$];
      words = '{16'h0000, 16'h012C, 16'h012D, 16'h101E, 16'h101F, 16'h2003, 16'h2004,
                16'h7000, 16'h7001, 16'hF7FF, 16'hF00F, 16'hF00E, 16'hE096, 16'hD7FF,
                16'hD1F4, 16'h87FF, 16'h0FFF, 16'hF800, 16'hFFFF, 16'h7FFF};
      foreach (SPECIAL_CODES[i])
         words.push_back(SPECIAL_CODES[i]);
      foreach (words[i])
         send_word(words[i]);
      wait_for_drain();
   endtask

   task automatic test_output_hold();
      set_idling(1'b0, 1'b1);
      @(posedge clock);
      hold_left = 80;
      @(negedge clock);
      repeat (40)
         send_word(random_word());
      wait_for_drain();
      set_idling(1'b1, 1'b1);
   endtask

   task automatic test_random_words();
      for (int i = 0; i < 1300; i++) begin
         if (i == 400)
            set_idling(1'b0, 1'b0);
         if (i == 550)
            set_idling(1'b1, 1'b1);
         if (i == 900)
            wait_for_drain();
         send_word(random_word());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_words();
      test_output_hold();
      test_random_words();
      wait_for_drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d SFLOAT words (%0d special codes), under random idling and a long hold",
               words_sent, specials_sent);
      $display("Responses checked: %0d in range, %0d rejected", in_range_seen, rejected_seen);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
